FILE: hw/rtl/rc_gimbal_rate_command_safety_unit_macros.svh
// Assertion macros shared by the gimbal rate command safety RTL.
// Each macro expects clk and rst_n in scope.
`ifndef RC_GIMBAL_RATE_COMMAND_SAFETY_UNIT_MACROS_SVH
`define RC_GIMBAL_RATE_COMMAND_SAFETY_UNIT_MACROS_SVH

// Same-cycle implication.
`define RCGS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RCGS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rcgs_pkg.sv
// Types, constants and codes shared by the gimbal rate command safety RTL.
`timescale 1ns / 1ps
`default_nettype none

package rcgs_pkg;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_AVAIL  = 2'd2,
        MODE_REJECT = 2'd3
    } rcgs_mode_t;

    typedef struct packed {
        rcgs_mode_t  mode;
        logic [11:0] yaw_channel;
        logic [11:0] pitch_channel;
        logic        available_flag;
    } rcgs_in_t;

    typedef struct packed {
        logic signed [7:0] yaw_speed;
        logic signed [7:0] pitch_speed;
        logic              last;
    } rcgs_out_t;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DEADBAND      = 2'd0;
    localparam logic [1:0] REG_INPUT_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_STOP_RETRY    = 2'd2;
    localparam logic [1:0] REG_STOP_COPIES   = 2'd3;

    localparam logic [7:0]  DEADBAND_RST      = 8'd25;
    localparam logic [15:0] INPUT_TIMEOUT_RST = 16'd350;
    localparam logic [15:0] STOP_RETRY_RST    = 16'd100;
    localparam logic [3:0]  STOP_COPIES_RST   = 4'd3;
    localparam logic [3:0]  STOP_COPIES_MAX   = 4'd8;

    localparam logic [11:0] CH_MIN    = 12'd1050;
    localparam logic [11:0] CH_CENTER = 12'd1500;
    localparam logic [11:0] CH_MAX    = 12'd1950;
    localparam logic [11:0] SANE_MIN  = 12'd900;
    localparam logic [11:0] SANE_MAX  = 12'd2100;
    localparam logic [8:0]  CH_SPAN   = 9'd450;
    localparam logic [16:0] SCALE2    = 17'd200;
    localparam logic [6:0]  FULL_SPEED = 7'd100;

    // Quotient bits produced by the shared divider
    localparam int Q_W = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_YAW,
        ST_PITCH,
        ST_APPLY,
        ST_EMIT
    } rcgs_state_t;

    typedef enum logic {
        SCL_IDLE,
        SCL_RUN
    } rcgs_scl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rcgs_scl_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rcgs_scaler.sv
// Channel-to-speed scaler: clamp, deadband and a one-bit-per-cycle restoring divider.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_gimbal_rate_command_safety_unit_macros.svh"

module rcgs_scaler
    import rcgs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [11:0]       raw,
    input  wire logic [7:0]        deadband,
    output rcgs_scl_stat_t         stat,
    output logic signed [7:0]      speed
);

    rcgs_scl_state_t        state_reg, state_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [16:0]            rem_reg;
    logic [16:0]            dvs_reg;
    logic [Q_W-1:0]         q_reg;
    logic                   neg_reg;
    logic                   zero_reg;

    logic                   load_en;
    logic                   step_en;

    logic [11:0]            clamped;
    logic                   neg;
    logic [8:0]             mag;
    logic                   in_band;
    logic [8:0]             excess;
    logic [8:0]             span;
    logic [16:0]            num;
    logic [9:0]             den;
    logic [17:0]            diff;
    logic                   fits;
    logic [Q_W-1:0]         q_eff;
    logic [7:0]             mag8;

    // Operand setup from the raw channel
    always_comb
    begin
        if (raw < CH_MIN)
            clamped = CH_MIN;
        else if (raw > CH_MAX)
            clamped = CH_MAX;
        else
            clamped = raw;
        neg     = clamped < CH_CENTER;
        mag     = neg ? 9'(CH_CENTER - clamped) : 9'(clamped - CH_CENTER);
        in_band = mag <= {1'b0, deadband};
        excess  = mag - {1'b0, deadband};
        span    = CH_SPAN - {1'b0, deadband};
        // round half up: (200*e + d) / (2*d)
        num     = 17'(excess) * SCALE2 + 17'(span);
        den     = {span, 1'b0};
    end

    assign diff = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign fits = !diff[17];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            SCL_IDLE:
            begin
                if (start)
                begin
                    state_next = SCL_RUN;
                    cnt_next   = 3'(Q_W - 1);
                end
            end
            SCL_RUN:
            begin
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    state_next = SCL_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = SCL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load_en   = (state_reg == SCL_IDLE) && start;
        step_en   = (state_reg == SCL_RUN);
        stat.busy = (state_reg == SCL_RUN);
        stat.done = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCL_IDLE;
            cnt_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            rem_reg  <= num;
            dvs_reg  <= 17'(den) << (Q_W - 1);
            q_reg    <= '0;
            neg_reg  <= neg;
            zero_reg <= in_band;
        end
        else if (step_en)
        begin
            if (fits)
                rem_reg <= diff[16:0];
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    // Never less than 1 outside the deadband
    assign q_eff = (q_reg == '0) ? Q_W'(1) : q_reg;
    assign mag8  = 8'(q_eff);
    assign speed = zero_reg ? 8'sd0 : (neg_reg ? -$signed(mag8) : $signed(mag8));

    `RCGS_ASSERT_IMP(a_start_when_idle, start, state_reg == SCL_IDLE,
        "scaler started while busy")
    `RCGS_ASSERT_NXT(a_done_after_last_step, (state_reg == SCL_RUN) && (cnt_reg == 3'd0),
        done_reg, "scaler missed done after last step")
    `RCGS_ASSERT_IMP(a_speed_in_range, done_reg && !zero_reg, q_reg <= FULL_SPEED,
        "scaled speed above full scale")

endmodule

`default_nettype wire

FILE: hw/rtl/rc_gimbal_rate_command_safety_unit.sv
// Top level of the gimbal rate command safety unit: event sequencer, timers and result port.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_gimbal_rate_command_safety_unit_macros.svh"

// One item is taken at a time; in_ready is high only while the unit is idle.
// A channel sample that passes the check offers its first command after the
// check state, two passes through the shared scaler (yaw, then pitch, each a
// 7-step restoring divide plus a done cycle) and the update state for the
// session. Ticks, availability changes and rejections go from the check state
// straight to the update state. Results are offered one per cycle from
// out_valid while out_ready holds; a stop burst gives up to 8 zero commands
// and the last one carries last. in_ready returns in the cycle after the final
// transfer, or right after the update cycle when an item gives no result.
module rc_gimbal_rate_command_safety_unit
    import rcgs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire rcgs_in_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output rcgs_out_t       out_data,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    rcgs_state_t        state_reg, state_next;

    logic [7:0]         deadband_reg;
    logic [15:0]        timeout_reg;
    logic [15:0]        retry_ms_reg;
    logic [3:0]         copies_reg;

    logic               link_reg, link_next;
    logic               armed_reg, armed_next;
    logic               moving_reg, moving_next;
    logic [3:0]         left_reg, left_next;
    logic               wd_run_reg, wd_run_next;
    logic [15:0]        wd_cnt_reg, wd_cnt_next;
    logic               rt_run_reg, rt_run_next;
    logic [15:0]        rt_cnt_reg, rt_cnt_next;
    logic [3:0]         emit_left_reg, emit_left_next;
    logic               emit_cmd_reg, emit_cmd_next;

    rcgs_in_t           item_reg;
    logic signed [7:0]  ys_reg;
    logic signed [7:0]  ps_reg;

    logic               sane;
    logic               sample_go;
    logic               spd_zero;
    logic [3:0]         copies_eff;
    logic [3:0]         apply_count;

    logic               scl_start;
    logic [11:0]        scl_raw;
    rcgs_scl_stat_t     scl_stat;
    logic signed [7:0]  scl_speed;

    rcgs_scaler u_scaler (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scl_start),
        .raw      (scl_raw),
        .deadband (deadband_reg),
        .stat     (scl_stat),
        .speed    (scl_speed)
    );

    assign sane = (item_reg.yaw_channel >= SANE_MIN) && (item_reg.yaw_channel <= SANE_MAX)
               && (item_reg.pitch_channel >= SANE_MIN) && (item_reg.pitch_channel <= SANE_MAX);
    assign sample_go = (item_reg.mode == MODE_SAMPLE) && link_reg && sane;
    assign spd_zero  = (ys_reg == 8'sd0) && (ps_reg == 8'sd0);
    assign scl_raw   = (state_reg == ST_CHECK) ? item_reg.yaw_channel : item_reg.pitch_channel;

    always_comb
    begin
        if (copies_reg == 4'd0)
            copies_eff = 4'd1;
        else if (copies_reg > STOP_COPIES_MAX)
            copies_eff = STOP_COPIES_MAX;
        else
            copies_eff = copies_reg;
    end

    // Session update for one item, in the order the events take effect
    always_comb
    begin
        logic cancel_req;
        logic stop_req;
        logic flush_req;
        logic [3:0] n;

        cancel_req  = 1'b0;
        stop_req    = 1'b0;
        flush_req   = 1'b0;
        n           = 4'd0;
        link_next   = link_reg;
        armed_next  = armed_reg;
        moving_next = moving_reg;
        left_next   = left_reg;
        wd_run_next = wd_run_reg;
        wd_cnt_next = wd_cnt_reg;
        rt_run_next = rt_run_reg;
        rt_cnt_next = rt_cnt_reg;
        emit_cmd_next = 1'b0;

        if (state_reg == ST_APPLY)
        begin
            case (item_reg.mode)
                MODE_SAMPLE:
                begin
                    if (link_reg)
                    begin
                        if (!sane)
                            cancel_req = 1'b1;
                        else
                        begin
                            wd_run_next = 1'b1;
                            wd_cnt_next = 16'd0;
                            // disarmed and off center: only the watchdog restarts
                            if (armed_reg || spd_zero)
                            begin
                                if (!armed_reg)
                                begin
                                    armed_next  = 1'b1;
                                    moving_next = 1'b1;
                                end
                                if (spd_zero)
                                    stop_req = 1'b1;
                                else
                                begin
                                    rt_run_next   = 1'b0;
                                    rt_cnt_next   = 16'd0;
                                    left_next     = 4'd0;
                                    moving_next   = 1'b1;
                                    emit_cmd_next = 1'b1;
                                    n             = 4'd1;
                                end
                            end
                        end
                    end
                end
                MODE_TICK:
                begin
                    // retry timer advances before the watchdog
                    if (rt_run_reg)
                    begin
                        rt_cnt_next = rt_cnt_reg + 16'd1;
                        if (rt_cnt_next >= retry_ms_reg)
                        begin
                            rt_run_next = 1'b0;
                            rt_cnt_next = 16'd0;
                            if (left_reg != 4'd0)
                            begin
                                left_next = left_reg - 4'd1;
                                n         = 4'd1;
                                if (left_next != 4'd0)
                                    rt_run_next = 1'b1;
                            end
                        end
                    end
                    if (wd_run_reg)
                    begin
                        wd_cnt_next = wd_cnt_reg + 16'd1;
                        if (wd_cnt_next >= timeout_reg)
                            cancel_req = 1'b1;
                    end
                end
                MODE_AVAIL:
                begin
                    link_next = item_reg.available_flag;
                    if (!item_reg.available_flag)
                    begin
                        cancel_req = 1'b1;
                        flush_req  = 1'b1;
                    end
                end
                MODE_REJECT:
                begin
                    cancel_req = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (cancel_req)
            begin
                armed_next  = 1'b0;
                wd_run_next = 1'b0;
                wd_cnt_next = 16'd0;
                stop_req    = 1'b1;
            end
            // first stop copy goes out at once
            if (stop_req && moving_next)
            begin
                moving_next = 1'b0;
                left_next   = copies_eff - 4'd1;
                n           = n + 4'd1;
                if (left_next != 4'd0)
                begin
                    rt_run_next = 1'b1;
                    rt_cnt_next = 16'd0;
                end
            end
            // link lost: drain every remaining copy now
            if (flush_req)
            begin
                n           = n + left_next;
                left_next   = 4'd0;
                rt_run_next = 1'b0;
                rt_cnt_next = 16'd0;
            end
        end
        apply_count = n;
    end

    always_comb
    begin
        emit_left_next = emit_left_reg;
        if (state_reg == ST_APPLY)
            emit_left_next = apply_count;
        else if (out_valid && out_ready)
            emit_left_next = emit_left_reg - 4'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = sample_go ? ST_YAW : ST_APPLY;
            end
            ST_YAW:
            begin
                if (scl_stat.done)
                    state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                if (scl_stat.done)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = (apply_count != 4'd0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_ready && (emit_left_reg == 4'd1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        scl_start = ((state_reg == ST_CHECK) && sample_go)
                 || ((state_reg == ST_YAW) && scl_stat.done);
        out_data.yaw_speed   = emit_cmd_reg ? ys_reg : 8'sd0;
        out_data.pitch_speed = emit_cmd_reg ? ps_reg : 8'sd0;
        out_data.last        = (emit_left_reg == 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            deadband_reg  <= DEADBAND_RST;
            timeout_reg   <= INPUT_TIMEOUT_RST;
            retry_ms_reg  <= STOP_RETRY_RST;
            copies_reg    <= STOP_COPIES_RST;
            link_reg      <= 1'b0;
            armed_reg     <= 1'b0;
            moving_reg    <= 1'b0;
            left_reg      <= 4'd0;
            wd_run_reg    <= 1'b0;
            wd_cnt_reg    <= 16'd0;
            rt_run_reg    <= 1'b0;
            rt_cnt_reg    <= 16'd0;
            emit_left_reg <= 4'd0;
            emit_cmd_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            link_reg      <= link_next;
            armed_reg     <= armed_next;
            moving_reg    <= moving_next;
            left_reg      <= left_next;
            wd_run_reg    <= wd_run_next;
            wd_cnt_reg    <= wd_cnt_next;
            rt_run_reg    <= rt_run_next;
            rt_cnt_reg    <= rt_cnt_next;
            emit_left_reg <= emit_left_next;
            if (state_reg == ST_APPLY)
                emit_cmd_reg <= emit_cmd_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEADBAND:      deadband_reg <= cfg_data[7:0];
                    REG_INPUT_TIMEOUT: timeout_reg  <= cfg_data;
                    REG_STOP_RETRY:    retry_ms_reg <= cfg_data;
                    REG_STOP_COPIES:   copies_reg   <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if ((state_reg == ST_YAW) && scl_stat.done)
            ys_reg <= scl_speed;
        if ((state_reg == ST_PITCH) && scl_stat.done)
            ps_reg <= scl_speed;
    end

    `RCGS_ASSERT_IMP(a_one_side_at_a_time, out_valid, !in_ready,
        "input taken while results pending")
    `RCGS_ASSERT_IMP(a_emit_count_range, out_valid,
        (emit_left_reg != 4'd0) && (emit_left_reg <= STOP_COPIES_MAX),
        "result count out of range")
    `RCGS_ASSERT_IMP(a_command_is_single, out_valid && emit_cmd_reg, emit_left_reg == 4'd1,
        "speed command not a single last result")
    `RCGS_ASSERT_IMP(a_retry_only_when_stopped, rt_run_reg, !moving_reg,
        "retry timer running while motion active")
    `RCGS_ASSERT_IMP(a_left_below_max, 1'b1, left_reg < STOP_COPIES_MAX,
        "pending stop copies above limit")

endmodule

`default_nettype wire

FILE: test/tb_rc_gimbal_rate_command_safety_unit.sv
// Testbench for the gimbal rate command safety unit: event stimulus, command tracker and checks.
`timescale 1ns / 1ps

module tb_rc_gimbal_rate_command_safety_unit;
    import rcgs_pkg::*;

    // Tracks the session state of the unit and the rate/stop commands it still owes.
    class gimbal_command_tracker;
        logic [7:0]  deadband_us;
        logic [15:0] timeout_ticks;
        logic [15:0] retry_ticks;
        logic [3:0]  copies_cfg;
        bit          link_up;
        bit          armed;
        bit          moving;
        bit          watchdog_on;
        bit          retry_on;
        int unsigned copies_left;
        logic [15:0] watchdog_count;
        logic [15:0] retry_count;
        rcgs_out_t   pending_cmds[$];
        rcgs_out_t   burst[$];
        int          errors;
        int          checked;
        int          rate_cmds;
        int          stop_cmds;

        function new();
            deadband_us    = DEADBAND_RST;
            timeout_ticks  = INPUT_TIMEOUT_RST;
            retry_ticks    = STOP_RETRY_RST;
            copies_cfg     = STOP_COPIES_RST;
            link_up        = 1'b0;
            armed          = 1'b0;
            moving         = 1'b0;
            watchdog_on    = 1'b0;
            retry_on       = 1'b0;
            copies_left    = 0;
            watchdog_count = '0;
            retry_count    = '0;
            errors         = 0;
            checked        = 0;
            rate_cmds      = 0;
            stop_cmds      = 0;
        endfunction

        function void set_config(logic [7:0] db, logic [15:0] wd, logic [15:0] rt,
                                 logic [3:0] cp);
            deadband_us   = db;
            timeout_ticks = wd;
            retry_ticks   = rt;
            copies_cfg    = cp;
        endfunction

        // Clamp, center, apply deadband, scale with round-half-up.
        function logic signed [7:0] rate_of(logic [11:0] raw);
            int v;
            int off;
            int mag;
            int e;
            int d;
            v = int'(raw);
            if (v < int'(CH_MIN))
                v = int'(CH_MIN);
            if (v > int'(CH_MAX))
                v = int'(CH_MAX);
            off = v - int'(CH_CENTER);
            mag = (off < 0) ? -off : off;
            if (mag <= int'(deadband_us))
                return 8'sd0;
            e = mag - int'(deadband_us);
            d = int'(CH_MAX) - int'(CH_CENTER) - int'(deadband_us);
            mag = (2 * int'(FULL_SPEED) * e + d) / (2 * d);
            if (mag < 1)
                mag = 1;
            if (off < 0)
                mag = -mag;
            return mag[7:0];
        endfunction

        function void push_cmd(logic signed [7:0] yaw, logic signed [7:0] pitch);
            rcgs_out_t c;
            if (burst.size() >= int'(STOP_COPIES_MAX))
                return;
            c.yaw_speed   = yaw;
            c.pitch_speed = pitch;
            c.last        = 1'b0;
            burst.push_back(c);
            if (yaw == 0 && pitch == 0)
                stop_cmds++;
            else
                rate_cmds++;
        endfunction

        function void send_stop_copy();
            if (copies_left == 0)
                return;
            copies_left--;
            push_cmd(8'sd0, 8'sd0);
            if (copies_left > 0)
            begin
                retry_on    = 1'b1;
                retry_count = '0;
            end
        endfunction

        function void stop_motion();
            int unsigned c;
            c = copies_cfg;
            if (!moving)
                return;
            moving = 1'b0;
            if (c == 0)
                c = 1;
            if (c > int'(STOP_COPIES_MAX))
                c = int'(STOP_COPIES_MAX);
            copies_left = c;
            send_stop_copy();
        endfunction

        function void cancel_session();
            armed          = 1'b0;
            watchdog_on    = 1'b0;
            watchdog_count = '0;
            stop_motion();
        endfunction

        // Note one accepted event; returns 0 when the unit ignores it.
        function bit take_event(rcgs_in_t item);
            logic signed [7:0] ys;
            logic signed [7:0] ps;
            bit                wd;
            bit                effective;
            rcgs_out_t         c;
            burst.delete();
            effective = 1'b1;
            case (item.mode)
                MODE_SAMPLE:
                begin
                    if (!link_up)
                        effective = 1'b0;
                    else if (item.yaw_channel < SANE_MIN || item.yaw_channel > SANE_MAX ||
                             item.pitch_channel < SANE_MIN || item.pitch_channel > SANE_MAX)
                        cancel_session();
                    else
                    begin
                        ys = rate_of(item.yaw_channel);
                        ps = rate_of(item.pitch_channel);
                        watchdog_on    = 1'b1;
                        watchdog_count = '0;
                        // Disarmed and off center: only the watchdog restarts
                        if (armed || (ys == 0 && ps == 0))
                        begin
                            if (!armed)
                            begin
                                armed  = 1'b1;
                                moving = 1'b1;
                            end
                            if (ys == 0 && ps == 0)
                                stop_motion();
                            else
                            begin
                                retry_on    = 1'b0;
                                retry_count = '0;
                                copies_left = 0;
                                moving      = 1'b1;
                                push_cmd(ys, ps);
                            end
                        end
                    end
                end
                MODE_TICK:
                begin
                    wd = watchdog_on;
                    if (retry_on)
                    begin
                        retry_count = retry_count + 16'd1;
                        if (retry_count >= retry_ticks)
                        begin
                            retry_on    = 1'b0;
                            retry_count = '0;
                            send_stop_copy();
                        end
                    end
                    if (wd && watchdog_on)
                    begin
                        watchdog_count = watchdog_count + 16'd1;
                        if (watchdog_count >= timeout_ticks)
                        begin
                            watchdog_on    = 1'b0;
                            watchdog_count = '0;
                            cancel_session();
                        end
                    end
                end
                MODE_AVAIL:
                begin
                    link_up = item.available_flag;
                    if (!item.available_flag)
                    begin
                        cancel_session();
                        // Flush every remaining stop copy at once
                        while (copies_left > 0)
                            send_stop_copy();
                        retry_on    = 1'b0;
                        retry_count = '0;
                    end
                end
                default:
                    cancel_session();
            endcase
            foreach (burst[i])
            begin
                c      = burst[i];
                c.last = (i == burst.size() - 1);
                pending_cmds.push_back(c);
            end
            return effective;
        endfunction

        function void compare_command(rcgs_out_t got);
            rcgs_out_t want;
            if (pending_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected command: expected none, got yaw %0d pitch %0d last %0d",
                         $time, $signed(got.yaw_speed), $signed(got.pitch_speed), got.last);
                return;
            end
            want = pending_cmds.pop_front();
            checked++;
            if (got.yaw_speed !== want.yaw_speed)
            begin
                errors++;
                $display("%0t: yaw_speed mismatch: expected %0d, got %0d", $time,
                         $signed(want.yaw_speed), $signed(got.yaw_speed));
            end
            if (got.pitch_speed !== want.pitch_speed)
            begin
                errors++;
                $display("%0t: pitch_speed mismatch: expected %0d, got %0d", $time,
                         $signed(want.pitch_speed), $signed(got.pitch_speed));
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last mismatch: expected %0d, got %0d", $time,
                         want.last, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    rcgs_in_t    in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rcgs_out_t   out_data;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    bit          quiet = 1'b0;
    int          events_sent = 0;
    int          settings_used = 0;

    gimbal_command_tracker trk = new();

    rc_gimbal_rate_command_safety_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the result side at random, except during the quiet phase
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 9);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            trk.compare_command(out_data);

    initial
    begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic rcgs_in_t ev(rcgs_mode_t m, int yaw, int pitch, bit flag);
        rcgs_in_t it;
        it.mode           = m;
        it.yaw_channel    = yaw[11:0];
        it.pitch_channel  = pitch[11:0];
        it.available_flag = flag;
        return it;
    endfunction

    function automatic logic [11:0] neutral_width(int db);
        int w;
        w = int'(CH_CENTER) + int'($urandom_range(2 * db)) - db;
        return w[11:0];
    endfunction

    function automatic logic [11:0] stick_width(int db);
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return neutral_width(db);
        else if (r < 85)
            return 12'($urandom_range(int'(CH_MAX), int'(CH_MIN)));
        return 12'($urandom_range(int'(SANE_MAX), int'(SANE_MIN)));
    endfunction

    // Mostly well-formed sessions: bring the link up, arm, steer, tick; some noise.
    function automatic rcgs_in_t random_event();
        rcgs_in_t it;
        int       r;
        int       db;
        it.mode           = MODE_SAMPLE;
        it.yaw_channel    = 12'($urandom_range(4095));
        it.pitch_channel  = 12'($urandom_range(4095));
        it.available_flag = 1'($urandom_range(1));
        db = int'(trk.deadband_us);
        if (!trk.link_up && $urandom_range(99) < 75)
        begin
            it.mode           = MODE_AVAIL;
            it.available_flag = 1'b1;
            return it;
        end
        r = $urandom_range(99);
        if (r < 45)
        begin
            if (!trk.armed && $urandom_range(99) < 50)
            begin
                it.yaw_channel   = neutral_width(db);
                it.pitch_channel = neutral_width(db);
            end
            else if ($urandom_range(99) >= 8)
            begin
                it.yaw_channel   = stick_width(db);
                it.pitch_channel = stick_width(db);
            end
        end
        else if (r < 85)
            it.mode = MODE_TICK;
        else if (r < 94)
        begin
            it.mode           = MODE_AVAIL;
            it.available_flag = ($urandom_range(99) >= 40);
        end
        else
            it.mode = MODE_REJECT;
        return it;
    endfunction

    task automatic play(input rcgs_in_t item, output bit counted);
        if (!quiet && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 9);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        counted = trk.take_event(item);
        events_sent++;
    endtask

    // Hold the stream, wait for every owed command, then let the unit settle.
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (trk.pending_cmds.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] db, input logic [15:0] wd,
                                input logic [15:0] rt, input logic [3:0] cp);
        cfg_write <= 1'b1;
        cfg_index <= REG_DEADBAND;
        cfg_data  <= {8'd0, db};
        @(posedge clk);
        cfg_index <= REG_INPUT_TIMEOUT;
        cfg_data  <= wd;
        @(posedge clk);
        cfg_index <= REG_STOP_RETRY;
        cfg_data  <= rt;
        @(posedge clk);
        cfg_index <= REG_STOP_COPIES;
        cfg_data  <= {12'd0, cp};
        @(posedge clk);
        cfg_write <= 1'b0;
        trk.set_config(db, wd, rt, cp);
        settings_used++;
    endtask

    initial
    begin
        bit counted;
        int effective;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = REG_DEADBAND;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: link handling, arming, extremes of the channels
        settings_used = 1;
        play(ev(MODE_SAMPLE, 1500, 1500, 1'b0), counted);   // link down: ignored
        play(ev(MODE_AVAIL, 4095, 4095, 1'b1), counted);
        play(ev(MODE_SAMPLE, 1700, 1500, 1'b0), counted);   // disarmed, off center
        play(ev(MODE_SAMPLE, 1500, 1500, 1'b1), counted);   // arm: stop burst
        play(ev(MODE_SAMPLE, 1950, 1050, 1'b0), counted);   // full deflection
        play(ev(MODE_SAMPLE, 0, 0, 1'b0), counted);         // out of range: cancel
        play(ev(MODE_SAMPLE, 1500, 1500, 1'b0), counted);
        play(ev(MODE_SAMPLE, 1526, 1474, 1'b0), counted);   // just past the deadband
        play(ev(MODE_SAMPLE, 2100, 900, 1'b0), counted);    // sane limits, clamped
        play(ev(MODE_SAMPLE, 2101, 899, 1'b0), counted);
        play(ev(MODE_REJECT, 4095, 0, 1'b1), counted);
        play(ev(MODE_AVAIL, 0, 4095, 1'b0), counted);       // link lost: flush copies
        drain();

        // Zero timers fire on the first tick; zero copies act as one
        program_regs(8'd200, 16'd0, 16'd0, 4'd0);
        play(ev(MODE_AVAIL, 0, 0, 1'b1), counted);
        play(ev(MODE_SAMPLE, 1500, 1500, 1'b0), counted);
        play(ev(MODE_SAMPLE, 1701, 1500, 1'b0), counted);
        play(ev(MODE_TICK, 0, 0, 1'b0), counted);
        play(ev(MODE_TICK, 4095, 4095, 1'b1), counted);
        play(ev(MODE_REJECT, 0, 0, 1'b0), counted);
        drain();

        // Copies above the cap, retry and watchdog on short counts
        program_regs(8'd0, 16'd4, 16'd2, 4'd15);
        play(ev(MODE_SAMPLE, 1500, 1500, 1'b0), counted);
        repeat (4) play(ev(MODE_TICK, 0, 0, 1'b0), counted);
        play(ev(MODE_SAMPLE, 1500, 1500, 1'b0), counted);
        play(ev(MODE_SAMPLE, 1501, 1499, 1'b0), counted);
        play(ev(MODE_AVAIL, 0, 0, 1'b0), counted);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: program_regs(8'd0, 16'd1, 16'd1, 4'd1);
                1: program_regs(8'd200, 16'hFFFF, 16'hFFFF, 4'd8);
                default:
                    program_regs(8'($urandom_range(200)), 16'($urandom_range(10, 1)),
                                 16'($urandom_range(4, 1)), 4'($urandom_range(8, 1)));
            endcase
            quiet <= (ph == 3);
            effective = 0;
            while (effective < 17)
            begin
                play(random_event(), counted);
                if (counted)
                    effective++;
            end
            drain();
        end

        if (trk.pending_cmds.size() != 0)
        begin
            trk.errors += trk.pending_cmds.size();
            $display("%0t: %0d expected commands never arrived", $time,
                     trk.pending_cmds.size());
        end
        $display("Drove %0d events under %0d register settings.", events_sent, settings_used);
        $display("Checked %0d commands: %0d rate, %0d stop.", trk.checked, trk.rate_cmds,
                 trk.stop_cmds);
        if (trk.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rcgs_pkg.sv
hw/rtl/rcgs_scaler.sv
hw/rtl/rc_gimbal_rate_command_safety_unit.sv
test/tb_rc_gimbal_rate_command_safety_unit.sv
